### sv/dcl_pkg.sv
// ----------------------------------------------------------------------------
// dcl_pkg
// Shared types, constants and controller codes for the density clustering
// labeler.
// ----------------------------------------------------------------------------
`default_nettype none

package dcl_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int IN_COORD_W = 16;
    localparam int PIDX_W     = 6;
    localparam int CNT_W      = 7;
    localparam int EPS_W      = 34;
    localparam int MINP_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 34;

    localparam logic [CFG_IDX_W-1:0] REG_EPSILON_SQUARED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS      = 1'd1;

    localparam logic [EPS_W-1:0]  EPS_RESET  = 34'd65536;
    localparam logic [MINP_W-1:0] MINP_RESET = 7'd4;

    typedef struct packed {
        logic signed [IN_COORD_W-1:0] coord_x;
        logic signed [IN_COORD_W-1:0] coord_y;
        logic signed [IN_COORD_W-1:0] coord_z;
        logic                         last_point;
    } point_t;

    typedef struct packed {
        logic [PIDX_W-1:0] point_index;
        logic [PIDX_W-1:0] cluster_label;
        logic              is_core;
        logic [CNT_W-1:0]  cluster_count;
        logic              last_result;
    } result_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PI_RD,
        ST_PI_LD,
        ST_NB_RD,
        ST_NB_SQ,
        ST_NB_ACC,
        ST_ROW_WR,
        ST_MG_ROW,
        ST_MG_PAIR,
        ST_MG_UPD,
        ST_MG_NEXT,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic pt_we;     // store point at j
        logic pt_re;     // read point store
        logic pt_sel_i;  // read address i, else j
        logic pi_ld;     // hold point i
        logic row_clr;   // clear neighbour row and count
        logic sq_en;     // squares stage
        logic acc_en;    // sum, compare, set row bit j
        logic row_we;    // write row i, core bit i, label i = i
        logic mx_re;     // read neighbour row i
        logic lab_re;    // read labels at i and j
        logic mg_en;     // merge the pair just read
        logic chg_clr;
        logic clu_clr;
        logic clu_en;
        logic out_ld;
        logic out_clr;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic core_i;
        logic row_bit;
        logic changed;
    } sts_t;

endpackage

`default_nettype wire

### sv/density_clustering_labeler.sv
// ----------------------------------------------------------------------------
// density_clustering_labeler
// Density-based clustering of up to MAX_POINTS 3-D points, one labelled
// result item per point once the data set is complete.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | item
//  ---------+----------------------------------+---------------------------
//  point    | point_valid, point_stall, point  | one point, Q8.8 x/y/z
//  result   | result_valid, result_stall, res. | index, label, core, count
//  config   | cfg_we, cfg_index, cfg_data      | register write
//
//  Sequence: a point is taken whenever point_valid is high while loading. The
//  final point starts the clustering run: a neighbour row for each point
//  (one point store read and one distance compare per pair), then
//  relaxation passes over the core points and their neighbours, repeated
//  until no label changes (at most n+1 passes), then a cluster count over
//  all labels and the result items in order of point index.
//  Reset: asynchronous, active low; returns to loading with default
//  registers. The point, row and label stores are not cleared.
//  Stalls: point_stall is low only while loading; a result item is held
//  in the output register until result_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module density_clustering_labeler
    import dcl_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  point_valid,
    output logic                       point_stall,
    input  wire point_t                point,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result
);

    localparam int IW = $clog2(MAX_POINTS);

    cmd_t          cmd;
    sts_t          sts;
    logic [IW-1:0] idx_i;
    logic [IW-1:0] idx_j;
    logic [IW-1:0] idx_last;

    // sequencer: owns the loop counters i, j and the last index
    dcl_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_last   (point.last_point),
        .point_stall  (point_stall),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd),
        .idx_i        (idx_i),
        .idx_j        (idx_j),
        .idx_last     (idx_last)
    );

    // stores, distance unit and result register
    dcl_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .IW          (IW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point        (point),
        .cmd          (cmd),
        .idx_i        (idx_i),
        .idx_j        (idx_j),
        .idx_last     (idx_last),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    // no new point while results of the last set are still going out
    a_no_load_during_output: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> point_stall)
        else $error("point taken while a result item is pending");

    // the final result item ends the output phase
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last_result) |=> !result_valid)
        else $error("result item after the final one");

    // a label is the least index of its cluster
    a_label_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.cluster_label <= result.point_index))
        else $error("cluster label above point index");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.cluster_count != '0))
        else $error("zero cluster count");

endmodule

`default_nettype wire

### sv/dcl_datapath.sv
// ----------------------------------------------------------------------------
// dcl_datapath
// Point store, distance unit, neighbour matrix, label store and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcl_datapath
    import dcl_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int IW          = $clog2(MAX_POINTS)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire point_t                point,
    input  wire cmd_t                  cmd,
    input  wire logic [IW-1:0]         idx_i,
    input  wire logic [IW-1:0]         idx_j,
    input  wire logic [IW-1:0]         idx_last,
    output sts_t                       sts,
    output logic                       result_valid,
    output result_t                    result
);

    localparam int CW  = COORD_WIDTH;
    localparam int XW  = (CW > IN_COORD_W) ? CW : IN_COORD_W;
    localparam int PW  = 3 * CW;
    localparam int DW  = CW + 1;
    localparam int QW  = 2 * DW;
    localparam int SW  = (QW > EPS_W) ? QW : EPS_W;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int MW  = (NW > MINP_W) ? NW + 1 : MINP_W + 1;

    // configuration
    logic [EPS_W-1:0]  eps_reg;
    logic [MINP_W-1:0] minp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= EPS_RESET;
            minp_reg <= MINP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EPSILON_SQUARED: eps_reg  <= cfg_data[EPS_W-1:0];
                REG_MIN_POINTS:      minp_reg <= cfg_data[MINP_W-1:0];
                default:             ;
            endcase
        end
    end

    // low CW bits of the field, two's complement
    function automatic logic [CW-1:0] trim(input logic [IN_COORD_W-1:0] raw);
        logic [XW-1:0] w;
        w = XW'(raw);
        return w[CW-1:0];
    endfunction

    // point store
    logic [PW-1:0] pt_mem [MAX_POINTS];
    logic [PW-1:0] pt_rd_reg;
    logic [PW-1:0] pi_reg;
    logic [PW-1:0] pt_wdata;
    logic [IW-1:0] pt_raddr;

    assign pt_wdata = {trim(point.coord_x), trim(point.coord_y), trim(point.coord_z)};
    assign pt_raddr = cmd.pt_sel_i ? idx_i : idx_j;

    always_ff @(posedge clk)
    begin
        if (cmd.pt_we)
            pt_mem[idx_j] <= pt_wdata;
        if (cmd.pt_re)
            pt_rd_reg <= pt_mem[pt_raddr];
        if (cmd.pi_ld)
            pi_reg <= pt_rd_reg;
    end

    // squared differences, one product per axis
    logic [QW-1:0] sq_reg [3];
    logic [QW-1:0] sq_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [DW-1:0] a;
            logic signed [DW-1:0] b;
            logic signed [DW-1:0] d;
            logic signed [QW-1:0] p;
            a = DW'($signed(pi_reg[k*CW +: CW]));
            b = DW'($signed(pt_rd_reg[k*CW +: CW]));
            d = a - b;
            p = QW'(d) * QW'(d);
            sq_next[k] = $unsigned(p);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_en)
        begin
            for (int k = 0; k < 3; k++)
                sq_reg[k] <= sq_next[k];
        end
    end

    // neighbour row of point i
    logic [SW-1:0]         dist_sum;
    logic                  hit;
    logic [MAX_POINTS-1:0] row_reg;
    logic [NW-1:0]         ncnt_reg;
    logic [MAX_POINTS-1:0] core_reg;
    logic                  core_now;

    assign dist_sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    assign hit      = dist_sum < SW'(eps_reg);
    assign core_now = MW'(ncnt_reg) >= MW'(minp_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.row_clr)
        begin
            row_reg  <= '0;
            ncnt_reg <= '0;
        end
        else if (cmd.acc_en && hit)
        begin
            row_reg[idx_j] <= 1'b1;
            ncnt_reg       <= ncnt_reg + NW'(1);
        end
        if (cmd.row_we)
            core_reg[idx_i] <= core_now;
    end

    // neighbour matrix
    logic [MAX_POINTS-1:0] mx_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] mx_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.row_we)
            mx_mem[idx_i] <= row_reg;
        if (cmd.mx_re)
            mx_rd_reg <= mx_mem[idx_i];
    end

    // label store: reads at i and j, one write
    logic [IW-1:0] lab_mem [MAX_POINTS];
    logic [IW-1:0] lab_a_reg;
    logic [IW-1:0] lab_b_reg;
    logic [IW-1:0] lab_lo;
    logic          lab_diff;
    logic          lab_we;
    logic [IW-1:0] lab_waddr;
    logic [IW-1:0] lab_wdata;

    assign lab_diff  = lab_a_reg != lab_b_reg;
    assign lab_lo    = (lab_a_reg < lab_b_reg) ? lab_a_reg : lab_b_reg;
    assign lab_we    = cmd.row_we || (cmd.mg_en && lab_diff);
    assign lab_waddr = cmd.row_we ? idx_i
                     : ((lab_a_reg > lab_b_reg) ? idx_i : idx_j);
    assign lab_wdata = cmd.row_we ? idx_i : lab_lo;

    always_ff @(posedge clk)
    begin
        if (lab_we)
            lab_mem[lab_waddr] <= lab_wdata;
        if (cmd.lab_re)
        begin
            lab_a_reg <= lab_mem[idx_i];
            lab_b_reg <= lab_mem[idx_j];
        end
    end

    logic changed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            changed_reg <= 1'b0;
        else if (cmd.chg_clr)
            changed_reg <= 1'b0;
        else if (cmd.mg_en && lab_diff)
            changed_reg <= 1'b1;
    end

    // cluster count: labels that name themselves
    logic [CNT_W-1:0] clu_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clu_clr)
            clu_reg <= '0;
        else if (cmd.clu_en && (lab_b_reg == idx_j))
            clu_reg <= clu_reg + CNT_W'(1);
    end

    // result register
    logic    res_valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.out_ld)
            res_valid_reg <= 1'b1;
        else if (cmd.out_clr)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            res_reg.point_index   <= PIDX_W'(idx_j);
            res_reg.cluster_label <= PIDX_W'(lab_b_reg);
            res_reg.is_core       <= core_reg[idx_j];
            res_reg.cluster_count <= clu_reg;
            res_reg.last_result   <= idx_j == idx_last;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign sts.core_i  = core_reg[idx_i];
    assign sts.row_bit = mx_rd_reg[idx_j];
    assign sts.changed = changed_reg;

endmodule

`default_nettype wire

### sv/dcl_ctrl.sv
// ----------------------------------------------------------------------------
// dcl_ctrl
// Sequencer: load, neighbour rows, label relaxation passes, count, output.
// ----------------------------------------------------------------------------
`default_nettype none

module dcl_ctrl
    import dcl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int IW         = $clog2(MAX_POINTS)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          point_valid,
    input  wire logic          point_last,
    output logic               point_stall,
    input  wire logic          result_stall,
    input  wire sts_t          sts,
    output cmd_t               cmd,
    output logic [IW-1:0]      idx_i,
    output logic [IW-1:0]      idx_j,
    output logic [IW-1:0]      idx_last
);

    localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_POINTS - 1);

    state_t        state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] last_reg, last_next;
    logic          i_end;
    logic          j_end;
    logic          accept;

    assign i_end  = i_reg == last_reg;
    assign j_end  = j_reg == last_reg;
    assign accept = point_valid && (state_reg == ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    j_next = j_reg + IW'(1);
                    if (point_last || (j_reg == LAST_SLOT))
                    begin
                        last_next  = j_reg;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_PI_RD;
                    end
                end
            end
            ST_PI_RD:  state_next = ST_PI_LD;
            ST_PI_LD:
            begin
                j_next     = '0;
                state_next = ST_NB_RD;
            end
            ST_NB_RD:  state_next = ST_NB_SQ;
            ST_NB_SQ:  state_next = ST_NB_ACC;
            ST_NB_ACC:
            begin
                if (j_end)
                    state_next = ST_ROW_WR;
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_NB_RD;
                end
            end
            ST_ROW_WR:
            begin
                if (i_end)
                begin
                    i_next     = '0;
                    state_next = ST_MG_ROW;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_PI_RD;
                end
            end
            ST_MG_ROW:
            begin
                if (sts.core_i)
                begin
                    j_next     = '0;
                    state_next = ST_MG_PAIR;
                end
                else
                    state_next = ST_MG_NEXT;
            end
            ST_MG_PAIR:
            begin
                if (sts.row_bit)
                    state_next = ST_MG_UPD;
                else if (j_end)
                    state_next = ST_MG_NEXT;
                else
                    j_next = j_reg + IW'(1);
            end
            ST_MG_UPD:
            begin
                if (j_end)
                    state_next = ST_MG_NEXT;
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_MG_PAIR;
                end
            end
            ST_MG_NEXT:
            begin
                if (i_end)
                begin
                    i_next = '0;
                    if (sts.changed)
                        state_next = ST_MG_ROW;
                    else
                    begin
                        j_next     = '0;
                        state_next = ST_CNT_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_MG_ROW;
                end
            end
            ST_CNT_RD: state_next = ST_CNT_CHK;
            ST_CNT_CHK:
            begin
                if (j_end)
                begin
                    j_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_LD;
            ST_OUT_LD: state_next = ST_OUT_HOLD;
            ST_OUT_HOLD:
            begin
                if (!result_stall)
                begin
                    if (j_end)
                    begin
                        j_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + IW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        point_stall = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                point_stall = 1'b0;
                cmd.pt_we   = point_valid;
            end
            ST_PI_RD:
            begin
                cmd.pt_re    = 1'b1;
                cmd.pt_sel_i = 1'b1;
            end
            ST_PI_LD:
            begin
                cmd.pi_ld   = 1'b1;
                cmd.row_clr = 1'b1;
            end
            ST_NB_RD:  cmd.pt_re  = 1'b1;
            ST_NB_SQ:  cmd.sq_en  = 1'b1;
            ST_NB_ACC: cmd.acc_en = 1'b1;
            ST_ROW_WR:
            begin
                cmd.row_we  = 1'b1;
                cmd.chg_clr = i_end;
            end
            ST_MG_ROW:  cmd.mx_re  = sts.core_i;
            ST_MG_PAIR: cmd.lab_re = sts.row_bit;
            ST_MG_UPD:  cmd.mg_en  = 1'b1;
            ST_MG_NEXT:
            begin
                cmd.chg_clr = i_end;
                cmd.clu_clr = i_end && !sts.changed;
            end
            ST_CNT_RD:   cmd.lab_re  = 1'b1;
            ST_CNT_CHK:  cmd.clu_en  = 1'b1;
            ST_OUT_RD:   cmd.lab_re  = 1'b1;
            ST_OUT_LD:   cmd.out_ld  = 1'b1;
            ST_OUT_HOLD: cmd.out_clr = !result_stall;
            default:     ;
        endcase
    end

    assign idx_i    = i_reg;
    assign idx_j    = j_reg;
    assign idx_last = last_reg;

endmodule

`default_nettype wire
